### design/disk_overlap_separation_assert.svh
// ----------------------------------------------------------------------------
// Disk overlap separation assertion macros
// Shared property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef DISK_OVERLAP_SEPARATION_ASSERT_SVH
`define DISK_OVERLAP_SEPARATION_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DOS_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define DOS_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/dos_pkg.sv
// ----------------------------------------------------------------------------
// Disk overlap separation package
// Payload types and fixed constants shared by the design files.
// ----------------------------------------------------------------------------
`default_nettype none

package dos_pkg;

  localparam int unsigned DirBits = 30;
  localparam int unsigned CfgW    = 16;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic [30:0]        first_radius;
    logic [30:0]        second_radius;
    logic [30:0]        first_mass;
    logic [30:0]        second_mass;
  } dos_in_t;

  typedef struct packed {
    logic signed [31:0] new_first_x;
    logic signed [31:0] new_first_y;
    logic signed [31:0] new_second_x;
    logic signed [31:0] new_second_y;
    logic               separated;
  } dos_out_t;

endpackage

`default_nettype wire

### design/dos_if.sv
// ----------------------------------------------------------------------------
// Disk overlap separation channel interfaces
// Valid/ready channels for input items, results and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface dos_in_if import dos_pkg::*; ();
  logic    valid;
  logic    ready;
  dos_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dos_out_if import dos_pkg::*; ();
  logic     valid;
  logic     ready;
  dos_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dos_cfg_if import dos_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CfgW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/disk_overlap_separation.sv
// ----------------------------------------------------------------------------
// Disk overlap separation
// 69 register stages from input transaction to result.
// Throughput: one transaction per cycle; the pipeline advances whenever the
// output stage is free, so a stall holds every stage in place.
// Stages: squares, 33 square-root digit stages, 31 quotient-bit stages with
// three dividers side by side (direction x, y and mass share), a direction,
// share and overlap stage, two multiply stages, then saturation into the
// output register. Reset clears all valid bits and sets min_distance to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_overlap_separation import dos_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  dos_in_if.sink    in_i,
  dos_out_if.source out_o,
  dos_cfg_if.sink   cfg_i
);

  localparam int unsigned SqS = 33;          // root digits
  localparam int unsigned DvS = 31;          // quotient bits (result < 2^31)
  localparam logic [31:0] One = 32'(64'd1 << FRAC_BITS);

  // ---------------- control ----------------
  logic advance;
  assign advance   = !out_o.valid || out_o.ready;
  assign in_i.ready = advance;
  assign cfg_i.ready = 1'b1;

  logic [CfgW-1:0] min_dist_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q <= CfgW'(1);
    end else if (cfg_i.valid) begin
      min_dist_q <= cfg_i.data;
    end
  end

  // ---------------- stage 0: differences and squares ----------------
  logic        v0_q;
  dos_in_t     p0_q;
  logic [32:0] ax0_q, ay0_q;
  logic        nx0_q, ny0_q;
  logic [65:0] sq0_q;

  logic signed [32:0] dx, dy;
  logic [32:0] ax, ay;
  assign dx = 33'(in_i.data.second_x) - 33'(in_i.data.first_x);
  assign dy = 33'(in_i.data.second_y) - 33'(in_i.data.first_y);
  assign ax = dx[32] ? 33'(-dx) : 33'(dx);
  assign ay = dy[32] ? 33'(-dy) : 33'(dy);

  // Squares of up to 33-bit magnitudes.
  function automatic logic [65:0] sq33(input logic [32:0] a);
    logic [65:0] r;
    begin
      r = 66'(a) * 66'(a);
      return r;
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (advance) begin
      v0_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      p0_q  <= in_i.data;
      ax0_q <= ax;
      ay0_q <= ay;
      nx0_q <= dx[32];
      ny0_q <= dy[32];
      sq0_q <= sq33(ax) + sq33(ay);
    end
  end

  // ---------------- square root pipeline ----------------
  logic        sv_q [SqS+1];
  dos_in_t     sp_q [SqS+1];
  logic [32:0] sax_q [SqS+1], say_q [SqS+1];
  logic        snx_q [SqS+1], sny_q [SqS+1];
  logic [65:0] srad_q [SqS+1];
  logic [34:0] srem_q [SqS+1];
  logic [32:0] sroot_q [SqS+1];

  always_comb begin
    sv_q[0]    = v0_q;
    sp_q[0]    = p0_q;
    sax_q[0]   = ax0_q;
    say_q[0]   = ay0_q;
    snx_q[0]   = nx0_q;
    sny_q[0]   = ny0_q;
    srad_q[0]  = sq0_q;
    srem_q[0]  = '0;
    sroot_q[0] = '0;
  end

  for (genvar s = 0; s < SqS; s++) begin : g_sqrt
    logic [34:0] rem_sh, trial;
    logic [32:0] root_sh;
    assign rem_sh  = {srem_q[s][32:0], srad_q[s][65:64]};
    assign root_sh = {sroot_q[s][31:0], 1'b0};
    assign trial   = {1'b0, root_sh, 1'b1};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[s+1] <= 1'b0;
      end else if (advance) begin
        sv_q[s+1] <= sv_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (advance) begin
        sp_q[s+1]   <= sp_q[s];
        sax_q[s+1]  <= sax_q[s];
        say_q[s+1]  <= say_q[s];
        snx_q[s+1]  <= snx_q[s];
        sny_q[s+1]  <= sny_q[s];
        srad_q[s+1] <= {srad_q[s][63:0], 2'b00};
        if (rem_sh >= trial) begin
          srem_q[s+1]  <= rem_sh - trial;
          sroot_q[s+1] <= root_sh | 33'd1;
        end else begin
          srem_q[s+1]  <= rem_sh;
          sroot_q[s+1] <= root_sh;
        end
      end
    end
  end

  // ---------------- coincidence select and divider setup ----------------
  logic [32:0] root;
  logic        coinc;
  assign root  = sroot_q[SqS];
  assign coinc = (root < 33'(min_dist_q)) || (root == '0);

  logic [32:0] dist_sel;
  assign dist_sel = coinc ? 33'(One) : root;

  logic [32:0] msum;
  assign msum = 33'(sp_q[SqS].first_mass) + 33'(sp_q[SqS].second_mass);

  // Three restoring dividers share the pipeline: ax/dist, ay/dist, m1/msum.
  // Dividend is N << 30, quotient < 2^31 in all cases that are used.
  logic        dv_q  [DvS+1];
  dos_in_t     dp_q  [DvS+1];
  logic        dco_q [DvS+1], dnx_q [DvS+1], dny_q [DvS+1], dmz_q [DvS+1];
  logic [32:0] ddist_q [DvS+1], dms_q [DvS+1];
  logic        nxb, nyb, nmb;
  logic [33:0] rxa_q [DvS+1], rya_q [DvS+1], rma_q [DvS+1];
  logic [30:0] qx_q [DvS+1], qy_q [DvS+1], qm_q [DvS+1];

  always_comb begin
    dv_q[0]    = sv_q[SqS];
    dp_q[0]    = sp_q[SqS];
    dco_q[0]   = coinc;
    dnx_q[0]   = snx_q[SqS];
    dny_q[0]   = sny_q[SqS];
    dmz_q[0]   = (msum == '0);
    ddist_q[0] = dist_sel;
    dms_q[0]   = (msum == '0) ? 33'd1 : msum;
    nxb        = sax_q[SqS][0];
    nyb        = say_q[SqS][0];
    nmb        = sp_q[SqS].first_mass[0];
    // Bits above the 31 quotient bits: seed remainder with the top bits.
    rxa_q[0]   = 34'(sax_q[SqS] >> 1);
    rya_q[0]   = 34'(say_q[SqS] >> 1);
    rma_q[0]   = 34'(sp_q[SqS].first_mass >> 1);
    qx_q[0]    = '0;
    qy_q[0]    = '0;
    qm_q[0]    = '0;
  end

  // One quotient bit per stage; dividend bit index 30-s of the (N<<30) word
  // where the high part N>>1 is the seed and N[0] is bit 30.
  for (genvar s = 0; s < DvS; s++) begin : g_div
    logic [33:0] tx, ty, tm;
    logic        bx, by, bm;
    assign bx = (s == 0) ? nxb : 1'b0;
    assign by = (s == 0) ? nyb : 1'b0;
    assign bm = (s == 0) ? nmb : 1'b0;
    assign tx = {rxa_q[s][32:0], bx};
    assign ty = {rya_q[s][32:0], by};
    assign tm = {rma_q[s][32:0], bm};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s+1] <= 1'b0;
      end else if (advance) begin
        dv_q[s+1] <= dv_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (advance) begin
        dp_q[s+1]    <= dp_q[s];
        dco_q[s+1]   <= dco_q[s];
        dnx_q[s+1]   <= dnx_q[s];
        dny_q[s+1]   <= dny_q[s];
        dmz_q[s+1]   <= dmz_q[s];
        ddist_q[s+1] <= ddist_q[s];
        dms_q[s+1]   <= dms_q[s];
        rxa_q[s+1]   <= (tx >= 34'(ddist_q[s])) ? tx - 34'(ddist_q[s]) : tx;
        rya_q[s+1]   <= (ty >= 34'(ddist_q[s])) ? ty - 34'(ddist_q[s]) : ty;
        rma_q[s+1]   <= (tm >= 34'(dms_q[s])) ? tm - 34'(dms_q[s]) : tm;
        qx_q[s+1]    <= {qx_q[s][29:0], tx >= 34'(ddist_q[s])};
        qy_q[s+1]    <= {qy_q[s][29:0], ty >= 34'(ddist_q[s])};
        qm_q[s+1]    <= {qm_q[s][29:0], tm >= 34'(dms_q[s])};
      end
    end
  end

  // ---------------- E1: direction, shares, overlap ----------------
  localparam logic [30:0] Half = 31'(1 << (DirBits - 1));
  localparam logic [30:0] Full = 31'(1 << DirBits);

  logic [30:0] dirx_e, diry_e, sh1_e, sh2_e;
  logic [32:0] rsum_e;
  assign dirx_e = dco_q[DvS] ? Full : qx_q[DvS];
  assign diry_e = dco_q[DvS] ? '0 : qy_q[DvS];
  assign sh1_e  = dmz_q[DvS] ? Half : qm_q[DvS];
  // share2 = floor(m2*2^30/msum) = 2^30 - share1 - (remainder != 0)
  assign sh2_e  = dmz_q[DvS] ? Half :
                  31'(Full - qm_q[DvS] - 31'(rma_q[DvS] != '0));
  assign rsum_e = 33'(dp_q[DvS].first_radius) + 33'(dp_q[DvS].second_radius);

  logic        e1v_q, e1sep_q, e1nx_q, e1ny_q;
  dos_in_t     e1p_q;
  logic [30:0] e1dx_q, e1dy_q, e1s1_q, e1s2_q;
  logic [32:0] e1ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1v_q <= 1'b0;
    end else if (advance) begin
      e1v_q <= dv_q[DvS];
    end
  end
  always_ff @(posedge clk_i) begin
    if (advance) begin
      e1p_q   <= dp_q[DvS];
      e1sep_q <= rsum_e > ddist_q[DvS];
      e1ov_q  <= rsum_e - ddist_q[DvS];
      e1nx_q  <= dco_q[DvS] ? 1'b0 : dnx_q[DvS];
      e1ny_q  <= dco_q[DvS] ? 1'b0 : dny_q[DvS];
      e1dx_q  <= dirx_e;
      e1dy_q  <= diry_e;
      e1s1_q  <= sh1_e;
      e1s2_q  <= sh2_e;
    end
  end

  // ---------------- E2: move lengths (33x31) ----------------
  logic        e2v_q, e2sep_q, e2nx_q, e2ny_q;
  dos_in_t     e2p_q;
  logic [30:0] e2dx_q, e2dy_q;
  logic [32:0] e2m1_q, e2m2_q;
  logic [63:0] pm1, pm2;
  assign pm1 = 64'(e1ov_q) * 64'(e1s2_q);
  assign pm2 = 64'(e1ov_q) * 64'(e1s1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e2v_q <= 1'b0;
    end else if (advance) begin
      e2v_q <= e1v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (advance) begin
      e2p_q   <= e1p_q;
      e2sep_q <= e1sep_q;
      e2nx_q  <= e1nx_q;
      e2ny_q  <= e1ny_q;
      e2dx_q  <= e1dx_q;
      e2dy_q  <= e1dy_q;
      e2m1_q  <= pm1[62:30];
      e2m2_q  <= pm2[62:30];
    end
  end

  // ---------------- E3: corrections ----------------
  logic        e3v_q, e3sep_q, e3nx_q, e3ny_q;
  dos_in_t     e3p_q;
  logic [33:0] c1x_q, c1y_q, c2x_q, c2y_q;
  logic [63:0] p1x, p1y, p2x, p2y;
  assign p1x = 64'(e2m1_q) * 64'(e2dx_q);
  assign p1y = 64'(e2m1_q) * 64'(e2dy_q);
  assign p2x = 64'(e2m2_q) * 64'(e2dx_q);
  assign p2y = 64'(e2m2_q) * 64'(e2dy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e3v_q <= 1'b0;
    end else if (advance) begin
      e3v_q <= e2v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (advance) begin
      e3p_q   <= e2p_q;
      e3sep_q <= e2sep_q;
      e3nx_q  <= e2nx_q;
      e3ny_q  <= e2ny_q;
      c1x_q   <= p1x[63:30];
      c1y_q   <= p1y[63:30];
      c2x_q   <= p2x[63:30];
      c2y_q   <= p2y[63:30];
    end
  end

  // ---------------- E4: apply and saturate, output register ----------------
  function automatic logic [31:0] sat(input logic signed [35:0] v);
    logic [31:0] r;
    begin
      if (v > 36'sd2147483647) r = 32'h7FFF_FFFF;
      else if (v < -36'sd2147483648) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
    end
  endfunction

  function automatic logic signed [35:0] sgn(input logic [33:0] m, input logic neg);
    logic signed [35:0] r;
    begin
      r = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
      return r;
    end
  endfunction

  dos_out_t res;
  always_comb begin
    res.separated = e3sep_q;
    if (e3sep_q) begin
      res.new_first_x  = sat(36'(e3p_q.first_x) - sgn(c1x_q, e3nx_q));
      res.new_first_y  = sat(36'(e3p_q.first_y) - sgn(c1y_q, e3ny_q));
      res.new_second_x = sat(36'(e3p_q.second_x) + sgn(c2x_q, e3nx_q));
      res.new_second_y = sat(36'(e3p_q.second_y) + sgn(c2y_q, e3ny_q));
    end else begin
      res.new_first_x  = e3p_q.first_x;
      res.new_first_y  = e3p_q.first_y;
      res.new_second_x = e3p_q.second_x;
      res.new_second_y = e3p_q.second_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o.valid <= 1'b0;
    end else if (advance) begin
      out_o.valid <= e3v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_o.data <= res;
    end
  end

endmodule

`default_nettype wire

### design/dos_checker.sv
// ----------------------------------------------------------------------------
// Disk overlap separation port checker
// Watches the top-level channels over time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "disk_overlap_separation_assert.svh"

module dos_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire in_valid_i,
  input wire in_ready_i,
  input wire out_valid_i,
  input wire out_ready_i,
  input wire out_sep_i,
  input wire [31:0] out_fx_i
);

  `DOS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `DOS_ASSERT_NXT(a_sep_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_sep_i) && $stable(out_fx_i))
  `DOS_ASSERT_IMP(a_ready_free, clk_i, rst_ni, !out_valid_i, in_ready_i)
  `DOS_ASSERT_IMP(a_stall_back, clk_i, rst_ni, out_valid_i && !out_ready_i, !in_ready_i)

  logic unused_ok;
  assign unused_ok = in_valid_i;

endmodule

bind disk_overlap_separation dos_checker u_dos_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_sep_i   (out_o.data.separated),
  .out_fx_i    (out_o.data.new_first_x)
);

`default_nettype wire

### verif/disk_overlap_separation_test.sv
// ----------------------------------------------------------------------------
// Disk overlap separation testbench
// Streams disk pairs through the block under random source gaps and sink
// stalls, across several min_distance settings. Each result is checked
// field by field against its typed expected value or a local model of the separation arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module disk_overlap_separation_test;
  import dos_pkg::*;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DrainCycles = 160;

  typedef struct {
    dos_in_t  item;
    bit       typed;
    dos_out_t res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  dos_in_if  in_ch ();
  dos_out_if out_ch ();
  dos_cfg_if cfg_ch ();

  disk_overlap_separation #(.FRAC_BITS(FracBits)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  logic [15:0] min_dist_q;
  dos_out_t    pending_q[$];
  dos_out_t    typed_q[$];
  bit          typed_flag_q[$];
  int unsigned mismatches;
  bit          sink_idle_en;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [31:0] sat_pos(longint v);
    if (v > 64'sd2147483647) begin
      return 32'h7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic dos_out_t separate_disks(dos_in_t d, logic [15:0] min_dist);
    longint            x1, y1, x2, y2, dx, dy, cx, cy;
    logic [65:0]       ax, ay, sq;
    logic [67:0]       rem, trial;
    logic [63:0]       root, dist_v, dir_x, dir_y, rsum, msum, overlap;
    logic [63:0]       share1, share2, move1, move2;
    logic [63:0]       m1, m2;
    bit                nx, ny;
    dos_out_t          r;
    x1 = d.first_x;
    y1 = d.first_y;
    x2 = d.second_x;
    y2 = d.second_y;
    dx = x2 - x1;
    dy = y2 - y1;
    nx = dx < 0;
    ny = dy < 0;
    ax = nx ? -dx : dx;
    ay = ny ? -dy : dy;
    sq = ax * ax + ay * ay;
    rem = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | ((sq >> (2 * i)) & 66'd3);
      root = root << 1;
      trial = {root, 1'b1};
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 64'd1;
      end
    end
    dist_v = root;
    if (dist_v < min_dist || dist_v == 0) begin
      dist_v = 64'd1 << FracBits;
      dir_x = 64'd1 << DirBits;
      dir_y = 0;
      nx = 0;
      ny = 0;
    end else begin
      dir_x = (ax[63:0] << DirBits) / dist_v;
      dir_y = (ay[63:0] << DirBits) / dist_v;
    end
    r.new_first_x = d.first_x;
    r.new_first_y = d.first_y;
    r.new_second_x = d.second_x;
    r.new_second_y = d.second_y;
    r.separated = 1'b0;
    rsum = 64'(d.first_radius) + 64'(d.second_radius);
    if (rsum > dist_v) begin
      overlap = rsum - dist_v;
      m1 = d.first_mass;
      m2 = d.second_mass;
      msum = m1 + m2;
      if (msum == 0) begin
        share1 = 64'd1 << (DirBits - 1);
        share2 = share1;
      end else begin
        share1 = (m1 << DirBits) / msum;
        share2 = (m2 << DirBits) / msum;
      end
      move1 = (overlap * share2) >> DirBits;
      move2 = (overlap * share1) >> DirBits;
      cx = longint'((move1 * dir_x) >> DirBits);
      cy = longint'((move1 * dir_y) >> DirBits);
      r.new_first_x = sat_pos(x1 - (nx ? -cx : cx));
      r.new_first_y = sat_pos(y1 - (ny ? -cy : cy));
      cx = longint'((move2 * dir_x) >> DirBits);
      cy = longint'((move2 * dir_y) >> DirBits);
      r.new_second_x = sat_pos(x2 + (nx ? -cx : cx));
      r.new_second_y = sat_pos(y2 + (ny ? -cy : cy));
      r.separated = 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // transaction monitor: prediction on input, compare on output
  always @(posedge clk_i) begin
    dos_out_t e;
    dos_out_t a;
    if (rst_ni && cfg_ch.valid && cfg_ch.ready) begin
      min_dist_q <= cfg_ch.data;
    end
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      if (typed_flag_q.size() != 0 && typed_flag_q[0]) begin
        pending_q.push_back(typed_q.pop_front());
      end else begin
        pending_q.push_back(separate_disks(in_ch.data, min_dist_q));
      end
      if (typed_flag_q.size() != 0) begin
        void'(typed_flag_q.pop_front());
      end
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (pending_q.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result %h", $time, a);
      end else begin
        e = pending_q.pop_front();
        check_field("new_first_x", e.new_first_x, a.new_first_x);
        check_field("new_first_y", e.new_first_y, a.new_first_y);
        check_field("new_second_x", e.new_second_x, a.new_second_x);
        check_field("new_second_y", e.new_second_y, a.new_second_y);
        check_field("separated", 32'(e.separated), 32'(a.separated));
      end
    end
  end

  // result sink with random stalls
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      stall = sink_idle_en ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  task automatic send_pair(dos_in_t d, bit src_idle);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= d;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic write_min_dist(logic [15:0] v);
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic dos_in_t random_pair(logic [15:0] min_dist);
    dos_in_t d;
    int unsigned span;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    d.first_x = $urandom();
    d.first_y = $urandom();
    d.second_x = $urandom();
    d.second_y = $urandom();
    d.first_radius = $urandom();
    d.second_radius = $urandom();
    d.first_mass = $urandom();
    d.second_mass = $urandom();
    if (kind < 7) begin
      span = (kind < 2) ? (32'd1 << 17) : (32'd1 << $urandom_range(4, 26));
      d.second_x = d.first_x + $signed($urandom_range(0, span)) - $signed(span / 2);
      d.second_y = d.first_y + $signed($urandom_range(0, span)) - $signed(span / 2);
      d.first_radius = $urandom_range(0, span);
      d.second_radius = $urandom_range(0, span);
      if (kind == 0) begin
        d.second_x = d.first_x + $signed($urandom_range(0, 2 * min_dist)) - $signed(min_dist);
        d.second_y = d.first_y;
      end
      if (kind == 1) begin
        d.first_mass = $urandom_range(1, 1 << 20);
        d.second_mass = $urandom_range(1, 1 << 20);
      end
    end
    return d;
  endfunction

  initial begin
    stim_row_t   rows[$];
    stim_row_t   row;
    logic [15:0] cfg_vals[4];
    mismatches = 0;
    sink_idle_en = 1'b1;
    min_dist_q = 16'd1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // coincident centres, equal masses: split 1.0 of overlap along +x
    row.item = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'h10000, 31'h10000, 31'h10000, 31'h10000};
    row.typed = 1;
    row.res = '{-32'sd32768, 32'sd0, 32'sd32768, 32'sd0, 1'b1};
    rows.push_back(row);
    // far apart, zero radii: pass through
    row.item = '{32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 31'd0, 31'd0,
                 31'h7fffffff, 31'h7fffffff};
    row.res = '{32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b0};
    rows.push_back(row);
    // coincident at the positive limit, huge radii: second clamps
    row.item = '{32'h7fffffff, 32'sd0, 32'h7fffffff, 32'sd0, 31'h7fffffff, 31'h7fffffff,
                 31'd5, 31'd5};
    row.res = '{32'sd32768, 32'sd0, 32'h7fffffff, 32'sd0, 1'b1};
    rows.push_back(row);
    row.typed = 0;
    row.item = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff,
                 31'h7fffffff, 31'h7fffffff, 31'h7fffffff};
    rows.push_back(row);
    row.item = '{32'sd0, 32'sd0, 32'sd100, 32'sd50, 31'd200, 31'd200, 31'd0, 31'd0};
    rows.push_back(row);
    row.item = '{32'sd0, 32'sd0, -32'sd100, -32'sd50, 31'd200, 31'd200, 31'd0, 31'd7};
    rows.push_back(row);
    row.item = '{32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 31'h7fffffff,
                 31'h7fffffff, 31'd1, 31'h7fffffff};
    rows.push_back(row);
    row.item = '{32'sd1000, 32'sd0, 32'sd1000, 32'sd1, 31'd3, 31'd0, 31'd1, 31'd1};
    rows.push_back(row);
    row.item = '{32'sd0, 32'sd0, 32'sd65536, 32'sd0, 31'd32768, 31'd32768, 31'd1, 31'd3};
    rows.push_back(row);
    row.item = '{32'sd0, 32'sd0, 32'sd65536, 32'sd0, 31'd32768, 31'd32769, 31'h7fffffff, 31'd1};
    rows.push_back(row);
    row.item = '{-32'sd5000, 32'sd7000, 32'sd3000, -32'sd4000, 31'h40000, 31'h40000,
                 31'h20000, 31'h10000};
    rows.push_back(row);

    foreach (rows[i]) begin
      typed_flag_q.push_back(rows[i].typed);
      if (rows[i].typed) begin
        typed_q.push_back(rows[i].res);
      end
      send_pair(rows[i].item, i > 5);
    end

    cfg_vals = '{16'd0, 16'hffff, 16'd1, 16'd0};
    cfg_vals[3] = $urandom();
    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        write_min_dist(cfg_vals[p - 1]);
        @(posedge clk_i);
      end
      sink_idle_en = (p != 2);
      for (int n = 0; n < 400; n++) begin
        send_pair(random_pair(min_dist_q), p != 3);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/dos_pkg.sv
design/dos_if.sv
design/disk_overlap_separation.sv
design/dos_checker.sv
verif/disk_overlap_separation_test.sv
